/* rtl/core/slge_pkg.sv */
`default_nettype none
package slge_pkg;

	localparam int TABLE_DEPTH_DEF      = 4096;
	localparam int MAX_ROW_FEATURES_DEF = 64;

	// Sigmoid / softplus tables over z in [-8, 8)
	localparam int SIG_ENTRIES = 256;
	localparam int KW          = $clog2(SIG_ENTRIES);

	localparam int IDX_W   = 12;
	localparam int VAL_W   = 32;
	localparam int ACC_W   = 48;
	localparam int LAMBDA_W = 31;
	localparam int PG_W    = 18;

	localparam logic signed [ACC_W-1:0] SCORE_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SCORE_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ZLIM      = ACC_W'(64'sd524288);

	localparam logic [63:0] ONE_Q32    = 64'd4294967296;
	localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_FEAT  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	localparam logic [1:0] MODE_FTRL = 2'd2;
	localparam logic       KIND_ROW  = 1'b0;
	localparam logic       KIND_READ = 1'b1;
	localparam logic       REG_MODE   = 1'b0;
	localparam logic       REG_LAMBDA = 1'b1;

	typedef enum logic [3:0] {
		S_SWEEP_ALL,
		S_SWEEP_GRAD,
		S_IDLE,
		S_FEAT_MUL,
		S_FEAT_ACC,
		S_FIN_Z,
		S_FIN_OUT,
		S_WALK_RD,
		S_WALK_ISS,
		S_WALK_MUL,
		S_WALK_WR,
		S_READ_OUT
	} state_t;

	typedef struct packed {
		logic    accept;
		action_t act;
		logic    sweep;
		logic    sweep_w;
		logic    feat_mul;
		logic    feat_acc;
		logic    fin_z;
		logic    fin_out;
		logic    walk_rd;
		logic    walk_iss;
		logic    walk_mul;
		logic    walk_wr;
		logic    row_end;
		logic    read_out;
		logic    clear_loss;
	} slge_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic last_feat;
		logic row_empty;
		logic walk_more;
		logic out_free;
	} slge_stat_t;

	typedef logic [31:0] tab_t [SIG_ENTRIES];

	// shift-subtract unsigned divide, only used while building the tables
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e^-a, a Q16.16 in [0, 8], result Q32
	function automatic logic [63:0] exp_neg_q32(input logic [63:0] a);
		logic [63:0] n;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] r;
		longint      sum;
		n    = a >> 16;
		x    = (a & 64'hFFFF) << 16;
		term = ONE_Q32;
		sum  = longint'(ONE_Q32);
		for (int i = 1; i <= 13; i++) begin
			term = udiv64((term * x) >> 32, 64'(i));
			if ((i & 1) == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		r = (sum < 0) ? 64'd0 : 64'(sum);
		if (r > ONE_Q32) r = ONE_Q32;
		for (int i = 0; i < 8; i++) begin
			if (64'(i) < n) r = (r * EXP_M1_Q32) >> 32;
		end
		return r;
	endfunction

	// ln(1+u), u Q32 in [0, 1], result Q16.16
	function automatic logic [63:0] ln1p_q16(input logic [63:0] u);
		logic [63:0] u30;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] pw;
		logic [63:0] sum;
		u30 = u >> 2;
		t   = udiv64(u30 << 30, (64'd2 << 30) + u30);
		t2  = (t * t) >> 30;
		pw  = t;
		sum = 64'd0;
		for (int k = 0; k < 12; k++) begin
			sum = sum + udiv64(pw, 64'(2 * k + 1));
			pw  = (pw * t2) >> 30;
		end
		return (64'd2 * sum) >> 14;
	endfunction

	function automatic tab_t build_tab(input logic want_sig);
		tab_t        res;
		longint      z;
		logic [63:0] a;
		logic [63:0] e;
		logic [63:0] v;
		for (int k = 0; k < SIG_ENTRIES; k++) begin
			z = longint'(udiv64((64'(2 * k + 1)) << 19, 64'(SIG_ENTRIES))) - 64'sd524288;
			a = 64'((z < 0) ? -z : z);
			e = exp_neg_q32(a);
			if (want_sig) begin
				if (z >= 0) v = udiv64(64'd1 << 48, ONE_Q32 + e);
				else v = udiv64(e << 16, ONE_Q32 + e);
			end else begin
				v = 64'((z >= 0) ? z : 0) + ln1p_q16(e);
			end
			res[k] = v[31:0];
		end
		return res;
	endfunction

	localparam tab_t SIG_TAB = build_tab(1'b1);
	localparam tab_t SP_TAB  = build_tab(1'b0);

endpackage
`default_nettype wire

/* rtl/core/sparse_logistic_gradient_engine_top.sv */
`default_nettype none
// Sparse logistic-regression gradient engine. Requests on the input channel
// load a weight, feed one feature of a sample row, read one gradient entry,
// or clear the gradient table and the loss sum. A feature request runs
// through weight memory read, 32x32 multiply and saturating score add. The
// request that carries last_feature then looks up sigmoid/softplus and
// posts the row-finished result, then walks each buffered feature through
// the gradient memory's read-modify-write loop (read buffer, read tables,
// multiply, write back). A weight load returns straight to idle; a
// gradient read posts its result once the output register is free. After
// reset and every clear request, a full-depth sweep writes zeros through
// the memories (weights and gradients after reset, gradients only on
// clear); no request is taken during the sweep, while APB register writes
// are taken at any time. Rows longer than MAX_ROW_FEATURES drop the extra
// features. Results wait in an output register, so a stalled consumer only
// holds the engine when it next has a result to post.
module sparse_logistic_gradient_engine_top #(
	parameter int TABLE_DEPTH      = slge_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_ROW_FEATURES = slge_pkg::MAX_ROW_FEATURES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         action,
	input  wire logic [slge_pkg::IDX_W-1:0]         feature_index,
	input  wire logic signed [slge_pkg::VAL_W-1:0]  feature_value,
	input  wire logic                               label_positive,
	input  wire logic                               last_feature,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    result_kind,
	output logic signed [slge_pkg::ACC_W-1:0]       row_score,
	output logic [slge_pkg::ACC_W-1:0]              loss_total,
	output logic signed [slge_pkg::VAL_W-1:0]       gradient_value,
	output logic [slge_pkg::IDX_W-1:0]              entry_index,
	// APB register port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [2:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);
	import slge_pkg::*;

	// config registers: mode at 0x0, lambda at 0x4
	logic [1:0]          mode_q;
	logic [LAMBDA_W-1:0] lambda_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			lambda_q <= '0;
		end else if (wr_en) begin
			if (paddr[2] == REG_MODE) mode_q <= pwdata[1:0];
			else lambda_q <= pwdata[LAMBDA_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_LAMBDA) ? {1'b0, lambda_q} : {30'd0, mode_q};

	slge_cmd_t  cmd;
	slge_stat_t stat;

	slge_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	slge_datapath #(
		.TABLE_DEPTH      (TABLE_DEPTH),
		.MAX_ROW_FEATURES (MAX_ROW_FEATURES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.feature_index  (feature_index),
		.feature_value  (feature_value),
		.label_positive (label_positive),
		.last_feature   (last_feature),
		.mode           (mode_q),
		.lambda         (lambda_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.row_score      (row_score),
		.loss_total     (loss_total),
		.gradient_value (gradient_value),
		.entry_index    (entry_index)
	);

endmodule
`default_nettype wire

/* rtl/core/slge_ctrl.sv */
`default_nettype none
module slge_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [1:0]         action,
	output logic                    in_stall,
	input  slge_pkg::slge_stat_t    stat,
	output slge_pkg::slge_cmd_t     cmd
);
	import slge_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_SWEEP_ALL;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.act  = action_t'(action);
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_SWEEP_ALL: begin
				cmd.sweep   = 1'b1;
				cmd.sweep_w = 1'b1;
				if (stat.sweep_last) state_d = S_IDLE;
			end
			S_SWEEP_GRAD: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (action_t'(action))
						ACT_LOAD:  state_d = S_IDLE;
						ACT_FEAT:  state_d = S_FEAT_MUL;
						ACT_READ:  state_d = S_READ_OUT;
						ACT_CLEAR: begin
							cmd.clear_loss = 1'b1;
							state_d = S_SWEEP_GRAD;
						end
					endcase
				end
			end
			S_FEAT_MUL: begin
				cmd.feat_mul = 1'b1;
				state_d = S_FEAT_ACC;
			end
			S_FEAT_ACC: begin
				cmd.feat_acc = 1'b1;
				state_d = stat.last_feat ? S_FIN_Z : S_IDLE;
			end
			S_FIN_Z: begin
				cmd.fin_z = 1'b1;
				state_d = S_FIN_OUT;
			end
			S_FIN_OUT: begin
				if (stat.out_free) begin
					cmd.fin_out = 1'b1;
					if (stat.row_empty) begin
						cmd.row_end = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_WALK_RD;
					end
				end
			end
			S_WALK_RD: begin
				cmd.walk_rd = 1'b1;
				state_d = S_WALK_ISS;
			end
			S_WALK_ISS: begin
				cmd.walk_iss = 1'b1;
				state_d = S_WALK_MUL;
			end
			S_WALK_MUL: begin
				cmd.walk_mul = 1'b1;
				state_d = S_WALK_WR;
			end
			S_WALK_WR: begin
				cmd.walk_wr = 1'b1;
				if (stat.walk_more) begin
					state_d = S_WALK_RD;
				end else begin
					cmd.row_end = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_READ_OUT: begin
				if (stat.out_free) begin
					cmd.read_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/slge_datapath.sv */
`default_nettype none
module slge_datapath #(
	parameter int TABLE_DEPTH      = slge_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_ROW_FEATURES = slge_pkg::MAX_ROW_FEATURES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  slge_pkg::slge_cmd_t              cmd,
	output slge_pkg::slge_stat_t             stat,
	input  wire logic [slge_pkg::IDX_W-1:0]  feature_index,
	input  wire logic signed [slge_pkg::VAL_W-1:0] feature_value,
	input  wire logic                        label_positive,
	input  wire logic                        last_feature,
	input  wire logic [1:0]                  mode,
	input  wire logic [slge_pkg::LAMBDA_W-1:0] lambda,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             result_kind,
	output logic signed [slge_pkg::ACC_W-1:0] row_score,
	output logic [slge_pkg::ACC_W-1:0]       loss_total,
	output logic signed [slge_pkg::VAL_W-1:0] gradient_value,
	output logic [slge_pkg::IDX_W-1:0]       entry_index
);
	import slge_pkg::*;

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IW  = (AW + 1 > IDX_W) ? AW + 1 : IDX_W + 1;
	localparam int RLW = $clog2(MAX_ROW_FEATURES + 1);
	localparam int BAW = (MAX_ROW_FEATURES > 1) ? $clog2(MAX_ROW_FEATURES) : 1;

	logic [VAL_W-1:0] wmem [TABLE_DEPTH];
	logic [VAL_W-1:0] gmem [TABLE_DEPTH];
	logic [IDX_W-1:0] ibuf [MAX_ROW_FEATURES];
	logic [VAL_W-1:0] vbuf [MAX_ROW_FEATURES];

	// control state
	logic [RLW-1:0]          row_len_q;
	logic [RLW-1:0]          walk_q;
	logic [AW-1:0]           sweep_q;
	logic signed [ACC_W-1:0] score_q;
	logic [ACC_W-1:0]        loss_q;
	logic                    out_valid_q;

	// payload
	logic [AW-1:0]           hold_addr_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    ok_q, take_q, label_q, last_q;
	logic [VAL_W-1:0]        wrd_q, grd_q;
	logic signed [63:0]      prod_s1;
	logic signed [ACC_W-1:0] z_s1;
	logic                    big_s1;
	logic [KW-1:0]           k_s1;
	logic signed [PG_W-1:0]  pg_q;
	logic [IDX_W-1:0]        bidx_s1;
	logic signed [VAL_W-1:0] bval_s1;
	logic                    ok_s2, ok_s3;
	logic [AW-1:0]           addr_s2, addr_s3;
	logic signed [PG_W+VAL_W-1:0] pgx_s2, pgx_s3;
	logic signed [63:0]      lw_s3;
	logic signed [VAL_W-1:0] g_s3;

	logic [IW-1:0] in_ext, b_ext;
	logic          in_ok, b_ok;
	logic [AW-1:0] in_addr, b_addr, raddr;

	assign in_ext  = IW'(feature_index);
	assign in_ok   = in_ext < IW'(TABLE_DEPTH);
	assign in_addr = in_ext[AW-1:0];
	assign b_ext   = IW'(bidx_s1);
	assign b_ok    = b_ext < IW'(TABLE_DEPTH);
	assign b_addr  = b_ext[AW-1:0];

	always_comb begin
		priority if (cmd.walk_iss) raddr = b_addr;
		else if (cmd.accept) raddr = in_addr;
		else raddr = hold_addr_q;
	end

	logic                    feat_acc_take, row_full;
	assign row_full      = row_len_q >= RLW'(MAX_ROW_FEATURES);
	assign feat_acc_take = cmd.accept && (cmd.act == ACT_FEAT) && !row_full;

	// weight memory
	logic          w_we;
	logic [AW-1:0] w_waddr;
	logic [VAL_W-1:0] w_wdata;
	assign w_we    = (cmd.sweep && cmd.sweep_w) ||
	                 (cmd.accept && (cmd.act == ACT_LOAD) && in_ok);
	assign w_waddr = cmd.sweep ? sweep_q : in_addr;
	assign w_wdata = cmd.sweep ? '0 : feature_value;

	always_ff @(posedge clk) begin
		if (w_we) wmem[w_waddr] <= w_wdata;
		wrd_q <= wmem[raddr];
	end

	// gradient memory
	logic signed [49:0] tsum;
	logic signed [VAL_W-1:0] tsat;
	logic          g_we;
	logic [AW-1:0] g_waddr;
	assign tsum = 50'(g_s3) + 50'(pgx_s3 >>> 16) +
	              ((mode != MODE_FTRL) ? 50'(lw_s3 >>> 16) : 50'sd0);
	always_comb begin
		if (tsum > 50'sh7FFFFFFF) tsat = 32'sh7FFFFFFF;
		else if (tsum < -50'sh80000000) tsat = 32'sh80000000;
		else tsat = tsum[VAL_W-1:0];
	end
	assign g_we    = cmd.sweep || (cmd.walk_wr && ok_s3);
	assign g_waddr = cmd.sweep ? sweep_q : addr_s3;

	always_ff @(posedge clk) begin
		if (g_we) gmem[g_waddr] <= cmd.sweep ? '0 : tsat;
		grd_q <= gmem[raddr];
	end

	// row buffers
	always_ff @(posedge clk) begin
		if (feat_acc_take) begin
			ibuf[row_len_q[BAW-1:0]] <= feature_index;
			vbuf[row_len_q[BAW-1:0]] <= feature_value;
		end
		if (cmd.walk_rd) begin
			bidx_s1 <= ibuf[walk_q[BAW-1:0]];
			bval_s1 <= vbuf[walk_q[BAW-1:0]];
		end
	end

	// score add
	logic signed [49:0] ssum;
	logic signed [ACC_W-1:0] ssat;
	assign ssum = 50'(score_q) + 50'(prod_s1 >>> 16);
	always_comb begin
		if (ssum > 50'(SCORE_MAX)) ssat = SCORE_MAX;
		else if (ssum < 50'(SCORE_MIN)) ssat = SCORE_MIN;
		else ssat = ssum[ACC_W-1:0];
	end

	// z, clamp and table index
	logic signed [ACC_W:0]   zn;
	logic signed [ACC_W-1:0] z48, zc;
	logic [19:0]             zoff;
	logic [33:0]             kprod;
	logic [33:0]             kk;
	assign zn  = label_q ? -(ACC_W+1)'(score_q) : (ACC_W+1)'(score_q);
	assign z48 = (zn > (ACC_W+1)'(SCORE_MAX)) ? SCORE_MAX : zn[ACC_W-1:0];
	always_comb begin
		if (z48 < -ZLIM) zc = -ZLIM;
		else if (z48 >= ZLIM) zc = ZLIM - ACC_W'(1);
		else zc = z48;
	end
	assign zoff  = 20'(zc + ZLIM);
	assign kprod = 34'(zoff) * 34'(SIG_ENTRIES);
	assign kk    = kprod >> 20;

	// loss update
	logic [ACC_W-1:0] sp;
	logic [ACC_W:0]   lsum;
	logic [ACC_W-1:0] loss_new;
	logic [31:0]      sig_v;
	assign sp       = big_s1 ? ACC_W'(z_s1) : ACC_W'(SP_TAB[k_s1]);
	assign lsum     = {1'b0, loss_q} + {1'b0, sp};
	assign loss_new = lsum[ACC_W] ? '1 : lsum[ACC_W-1:0];
	assign sig_v    = SIG_TAB[k_s1];

	logic out_load;
	assign out_load = cmd.fin_out || cmd.read_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q   <= '0;
			walk_q      <= '0;
			sweep_q     <= '0;
			score_q     <= '0;
			loss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep) begin
				sweep_q <= (sweep_q == AW'(TABLE_DEPTH - 1)) ? '0 : sweep_q + AW'(1);
			end
			if (feat_acc_take) row_len_q <= row_len_q + RLW'(1);
			if (cmd.feat_acc && take_q) score_q <= ssat;
			if (cmd.clear_loss) loss_q <= '0;
			if (cmd.fin_out) begin
				loss_q <= loss_new;
				walk_q <= '0;
			end
			if (cmd.walk_wr) walk_q <= walk_q + RLW'(1);
			if (cmd.row_end) begin
				score_q   <= '0;
				row_len_q <= '0;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hold_addr_q <= in_addr;
			idx_q       <= feature_index;
			val_q       <= feature_value;
			ok_q        <= in_ok;
			take_q      <= !row_full;
			label_q     <= label_positive;
			last_q      <= last_feature;
		end
		if (cmd.feat_mul) prod_s1 <= (ok_q ? $signed(wrd_q) : 32'sd0) * val_q;
		if (cmd.fin_z) begin
			z_s1   <= z48;
			big_s1 <= z48 >= ZLIM;
			k_s1   <= (kk >= 34'(SIG_ENTRIES)) ? KW'(SIG_ENTRIES - 1) : kk[KW-1:0];
		end
		if (cmd.fin_out) begin
			pg_q <= label_q ? -$signed(PG_W'(sig_v)) : $signed(PG_W'(sig_v));
		end
		if (cmd.walk_iss) begin
			ok_s2   <= b_ok;
			addr_s2 <= b_addr;
			pgx_s2  <= pg_q * bval_s1;
		end
		if (cmd.walk_mul) begin
			lw_s3   <= $signed({1'b0, lambda}) * $signed(wrd_q);
			g_s3    <= $signed(grd_q);
			pgx_s3  <= pgx_s2;
			ok_s3   <= ok_s2;
			addr_s3 <= addr_s2;
		end
		if (out_load) begin
			result_kind <= cmd.read_out ? KIND_READ : KIND_ROW;
			row_score   <= score_q;
			loss_total  <= cmd.read_out ? loss_q : loss_new;
			gradient_value <= (cmd.read_out && ok_q) ? $signed(grd_q) : '0;
			entry_index <= cmd.read_out ? idx_q : '0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.sweep_last = (sweep_q == AW'(TABLE_DEPTH - 1));
		stat.last_feat  = last_q;
		stat.row_empty  = (row_len_q == '0);
		stat.walk_more  = ((RLW+1)'(walk_q) + (RLW+1)'(1)) < (RLW+1)'(row_len_q);
		stat.out_free   = !out_valid_q || !out_stall;
	end

`ifndef SYNTHESIS
	a_row_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_len_q <= RLW'(MAX_ROW_FEATURES))
		else $error("row length above buffer depth");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> stat.out_free)
		else $error("result register loaded while a result is pending");

	a_row_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk_wr && !stat.walk_more) |=> (row_len_q == '0 && score_q == '0))
		else $error("row state not cleared after walk");
`endif

endmodule
`default_nettype wire

/* test/sparse_logistic_gradient_engine_top_tb.sv */
`default_nettype none
module sparse_logistic_gradient_engine_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import slge_pkg::*;

	localparam int DEPTH    = 4096;
	localparam int ROW_MAX  = 64;
	localparam int N_SIG    = 256;
	localparam int N_RANDOM = 1800;
	// walk of a full row after its result is posted, plus slack
	localparam int SETTLE   = 300;
	localparam longint unsigned Q32_ONE  = 64'd4294967296;
	localparam longint unsigned Q32_EM1  = 64'd1580030169;
	localparam longint          SCR_HI   = 64'sd140737488355327;
	localparam longint          SCR_LO   = -64'sd140737488355328;
	localparam longint          LOSS_HI  = 64'sd281474976710655;
	localparam longint          Z_EDGE   = 64'sd524288;

	typedef struct packed {
		logic        kind;
		logic [47:0] score;
		logic [47:0] loss;
		logic [31:0] grad;
		logic [11:0] idx;
	} row_result_t;

	typedef struct {
		action_t     act;
		logic [11:0] idx;
		logic [31:0] val;
		bit          lbl;
		bit          lst;
		bit          typed;
		row_result_t want;
	} plan_row_t;

	// ---------------------------------------------------------------
	// clock, DUT ports
	// ---------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	initial forever #5 clk = ~clk;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = 2'd0;
	logic [11:0] feature_index = '0;
	logic [31:0] feature_value = '0;
	logic        label_positive = 1'b0;
	logic        last_feature = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        result_kind;
	logic [47:0] row_score;
	logic [47:0] loss_total;
	logic [31:0] gradient_value;
	logic [11:0] entry_index;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sparse_logistic_gradient_engine_top dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .action, .feature_index, .feature_value,
		.label_positive, .last_feature,
		.out_valid, .out_stall, .result_kind, .row_score, .loss_total,
		.gradient_value, .entry_index,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	// ---------------------------------------------------------------
	// predictor state: tables, row buffer, accumulators, registers
	// ---------------------------------------------------------------
	int          weights [DEPTH];
	int          grads [DEPTH];
	logic [11:0] row_idx [ROW_MAX];
	int          row_val [ROW_MAX];
	int          row_len;
	longint      score_acc;
	longint      loss_acc;
	logic [1:0]  opt_mode;
	longint      l2_coef;
	longint      sigmoid_lut [N_SIG];
	longint      softplus_lut [N_SIG];

	row_result_t pending_q[$];
	int          n_errors = 0;
	bit          hold_go = 0;

	// e^-a, a Q16.16 in [0,8], Q32 result
	function automatic longint unsigned decay_q32(longint unsigned a);
		longint unsigned n, x, term, r;
		longint          sum;
		n    = a >> 16;
		x    = (a & 64'hFFFF) << 16;
		term = Q32_ONE;
		sum  = longint'(Q32_ONE);
		for (int i = 1; i <= 13; i++) begin
			term = ((term * x) >> 32) / longint'(i);
			sum  = (i % 2) ? sum - longint'(term) : sum + longint'(term);
		end
		r = (sum < 0) ? 0 : longint'(sum);
		if (r > Q32_ONE)
			r = Q32_ONE;
		for (longint unsigned i = 0; i < n; i++)
			r = (r * Q32_EM1) >> 32;
		return r;
	endfunction

	// ln(1+u), u Q32 in [0,1], Q16.16 result
	function automatic longint unsigned log1p_q16(longint unsigned u);
		longint unsigned u30, t, t2, pw, sum;
		u30 = u >> 2;
		t   = (u30 << 30) / ((64'd2 << 30) + u30);
		t2  = (t * t) >> 30;
		pw  = t;
		sum = 0;
		for (int k = 0; k < 12; k++) begin
			sum = sum + pw / longint'(2 * k + 1);
			pw  = (pw * t2) >> 30;
		end
		return (2 * sum) >> 14;
	endfunction

	task automatic build_luts();
		longint          z;
		longint unsigned a, e;
		for (int k = 0; k < N_SIG; k++) begin
			z = longint'((longint'(2 * k + 1) << 19) / N_SIG) - Z_EDGE;
			a = (z < 0) ? -z : z;
			e = decay_q32(a);
			if (z >= 0)
				sigmoid_lut[k] = longint'((64'd1 << 48) / (Q32_ONE + e));
			else
				sigmoid_lut[k] = longint'((e << 16) / (Q32_ONE + e));
			softplus_lut[k] = ((z >= 0) ? z : 0) + longint'(log1p_q16(e));
		end
	endtask

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// closes the row: loss update, gradient walk, returns the row result
	function automatic row_result_t close_row(bit lbl);
		row_result_t r;
		longint      z, zc, k, sp, pg, g;
		z  = clip(lbl ? -score_acc : score_acc, SCR_LO, SCR_HI);
		zc = clip(z, -Z_EDGE, Z_EDGE - 1);
		k  = ((zc + Z_EDGE) * N_SIG) >>> 20;
		if (k >= N_SIG)
			k = N_SIG - 1;
		sp = (z >= Z_EDGE) ? z : softplus_lut[k];
		loss_acc = clip(loss_acc + sp, 0, LOSS_HI);
		pg = lbl ? -sigmoid_lut[k] : sigmoid_lut[k];
		for (int i = 0; i < row_len; i++) begin
			g = (pg * longint'(row_val[i])) >>> 16;
			// ftrl drops the L2 term; every other mode code, the spare one too, keeps it
			if (opt_mode != MODE_FTRL)
				g += (l2_coef * longint'(weights[row_idx[i]])) >>> 16;
			grads[row_idx[i]] = int'(clip(longint'(grads[row_idx[i]]) + g,
				-64'sd2147483648, 64'sd2147483647));
		end
		r.kind  = KIND_ROW;
		r.score = score_acc[47:0];
		r.loss  = loss_acc[47:0];
		r.grad  = '0;
		r.idx   = '0;
		score_acc = 0;
		row_len   = 0;
		return r;
	endfunction

	// advances the predictor by one accepted request
	function automatic bit engine_step(action_t act, logic [11:0] idx, logic [31:0] val,
		bit lbl, bit lst, output row_result_t r);
		r = '0;
		case (act)
			ACT_LOAD: begin
				weights[idx] = int'(val);
				return 0;
			end
			ACT_FEAT: begin
				// a full buffer drops the feature, but its last mark still ends the row
				if (row_len < ROW_MAX) begin
					row_idx[row_len] = idx;
					row_val[row_len] = int'(val);
					row_len++;
					score_acc = clip(score_acc +
						((longint'(weights[idx]) * longint'(int'(val))) >>> 16),
						SCR_LO, SCR_HI);
				end
				if (!lst)
					return 0;
				r = close_row(lbl);
				return 1;
			end
			ACT_READ: begin
				r.kind  = KIND_READ;
				r.score = score_acc[47:0];
				r.loss  = loss_acc[47:0];
				r.grad  = grads[idx];
				r.idx   = idx;
				return 1;
			end
			default: begin
				// clear keeps weights and any row in progress
				foreach (grads[i])
					grads[i] = 0;
				loss_acc = 0;
				return 0;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// result checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		row_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{result_kind, row_score, loss_total, gradient_value, entry_index};
			if (pending_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("%0t: unexpected result %p", $realtime, got);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%0t: result mismatch\n  exp %p\n  got %p",
							$realtime, want, got);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver stall: random rate, redrawn periodically, plus a
	// long hold-off when asked for
	// ---------------------------------------------------------------
	initial begin
		int stall_pct;
		int cyc;
		stall_pct = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 0;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
			if (cyc % 256 == 0) begin
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2: stall_pct = 20;
					3: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			cyc++;
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// ---------------------------------------------------------------
	// sender: bursts of random length with random gaps
	// ---------------------------------------------------------------
	int burst_left = 0;
	bit gaps_on = 1;
	int n_sent = 0;

	task automatic push_req(action_t act, logic [11:0] idx, logic [31:0] val,
		bit lbl, bit lst, bit typed = 0, row_result_t typed_res = '0);
		row_result_t r;
		bit          has;
		in_valid       <= 1'b1;
		action         <= act;
		feature_index  <= idx;
		feature_value  <= val;
		label_positive <= lbl;
		last_feature   <= lst;
		do @(posedge clk); while (in_stall);
		has = engine_step(act, idx, val, lbl, lst, r);
		if (has)
			pending_q.push_back(typed ? typed_res : r);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			if (gaps_on && $urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	endtask

	// wait until every expected result has come, then let the walk finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(logic regsel, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {regsel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (regsel == REG_MODE)
			opt_mode = data[1:0];
		else
			l2_coef = longint'(data[30:0]);
	endtask

	function automatic logic [11:0] pick_idx();
		case ($urandom_range(0, 9))
			0: return 12'd4095;
			1, 2: return 12'($urandom);
			default: return 12'($urandom_range(0, 15));
		endcase
	endfunction

	function automatic logic [31:0] pick_val();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
		endcase
	endfunction

	// one random transaction: a row (the usual case), a load, a read or a clear
	task automatic random_txn(int row_len_max);
		int          pick;
		int          len;
		pick = $urandom_range(0, 199);
		if (pick < 30) begin
			push_req(ACT_LOAD, pick_idx(), pick_val(), 1'($urandom), 1'($urandom));
		end else if (pick < 150) begin
			len = $urandom_range(1, row_len_max);
			for (int i = 0; i < len; i++)
				push_req(ACT_FEAT, pick_idx(), pick_val(), 1'($urandom), i == len - 1);
		end else if (pick < 198) begin
			push_req(ACT_READ, pick_idx(), $urandom, 1'($urandom), 1'($urandom));
		end else begin
			push_req(ACT_CLEAR, pick_idx(), $urandom, 1'($urandom), 1'($urandom));
		end
	endtask

	// ---------------------------------------------------------------
	// directed plan: extremes, every action, saturation, clear
	// ---------------------------------------------------------------
	localparam row_result_t NO_RES = '0;
	plan_row_t plan [] = '{
		// fresh tables read back as zero
		'{ACT_READ, 12'd0,    32'h0,         0, 0, 1, '{KIND_READ, 48'd0, 48'd0, 32'd0, 12'd0}},
		'{ACT_READ, 12'd4095, 32'hFFFF_FFFF, 1, 1, 1,
			'{KIND_READ, 48'd0, 48'd0, 32'd0, 12'd4095}},
		'{ACT_LOAD, 12'd5,    32'h0001_0000, 0, 0, 0, NO_RES},
		'{ACT_LOAD, 12'd4095, 32'h7FFF_FFFF, 1, 1, 0, NO_RES},
		'{ACT_LOAD, 12'd0,    32'h8000_0000, 0, 0, 0, NO_RES},
		'{ACT_FEAT, 12'd5,    32'h0001_0000, 0, 0, 0, NO_RES},
		'{ACT_FEAT, 12'd4095, 32'h7FFF_FFFF, 1, 1, 0, NO_RES},
		// large positive z: loss takes z itself
		'{ACT_FEAT, 12'd0,    32'h8000_0000, 0, 1, 0, NO_RES},
		'{ACT_READ, 12'd5,    32'h0,         0, 0, 0, NO_RES},
		'{ACT_READ, 12'd4095, 32'h0,         0, 0, 0, NO_RES},
		'{ACT_READ, 12'd0,    32'h0,         0, 0, 0, NO_RES},
		// score saturation over three max products
		'{ACT_FEAT, 12'd4095, 32'h7FFF_FFFF, 0, 0, 0, NO_RES},
		'{ACT_FEAT, 12'd4095, 32'h7FFF_FFFF, 0, 0, 0, NO_RES},
		'{ACT_FEAT, 12'd4095, 32'h7FFF_FFFF, 0, 0, 0, NO_RES},
		'{ACT_READ, 12'd9,    32'h0,         0, 0, 0, NO_RES},
		'{ACT_FEAT, 12'd4095, 32'h7FFF_FFFF, 0, 1, 0, NO_RES},
		// clear wipes gradients and loss, weights stay
		'{ACT_CLEAR, 12'd0,   32'h0,         0, 0, 0, NO_RES},
		'{ACT_READ, 12'd5,    32'h0,         0, 0, 1, '{KIND_READ, 48'd0, 48'd0, 32'd0, 12'd5}},
		// zero-score row: middle of the tables, then a row with score -1.0
		'{ACT_FEAT, 12'd7,    32'h0,         1, 1, 0, NO_RES},
		'{ACT_FEAT, 12'd5,    32'hFFFF_0000, 1, 1, 0, NO_RES},
		'{ACT_READ, 12'd5,    32'h0,         0, 0, 0, NO_RES},
		'{ACT_READ, 12'd7,    32'h0,         0, 0, 0, NO_RES}
	};

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		logic [1:0]  modes [6]  = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1};
		logic [31:0] lambdas [6];
		int          phase;
		build_luts();
		foreach (weights[i]) begin
			weights[i] = 0;
			grads[i]   = 0;
		end
		row_len   = 0;
		score_acc = 0;
		loss_acc  = 0;
		opt_mode  = 2'd0;
		l2_coef   = 0;
		lambdas = '{32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_8000, 32'd1, $urandom};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_write(REG_MODE, 32'd0);
		reg_write(REG_LAMBDA, 32'd0);

		foreach (plan[i])
			push_req(plan[i].act, plan[i].idx, plan[i].val, plan[i].lbl, plan[i].lst,
				plan[i].typed, plan[i].want);
		wait_idle();

		phase = 0;
		while (n_sent < N_RANDOM + plan.size()) begin
			reg_write(REG_MODE, {30'd0, modes[phase % 6]});
			reg_write(REG_LAMBDA, {1'b0, lambdas[phase % 6][30:0]});
			gaps_on = (phase % 3 != 2);
			repeat (40) random_txn(8);
			// overlong row: features past the buffer are dropped
			for (int i = 0; i < 70; i++)
				push_req(ACT_FEAT, pick_idx(), pick_val(), 1'($urandom), i == 69);
			// sender pauses until all results are in
			while (pending_q.size() != 0) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			if (phase == 1) begin
				// long receiver hold-off while requests keep coming
				hold_go = 1;
				gaps_on = 0;
				repeat (30) random_txn(3);
				gaps_on = 1;
			end
			repeat (40) random_txn(8);
			wait_idle();
			phase++;
		end

		wait_idle();
		if (pending_q.size() != 0)
			n_errors++;
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// run limit
	initial begin
		#30ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
